### sv/lzw_code_decoder_defines.svh
// Assertion macros shared by the LZW code decoder RTL.
`ifndef LZW_CODE_DECODER_DEFINES_SVH
`define LZW_CODE_DECODER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define LCD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/lcd_pkg.sv
// Shared constants and types of the LZW code decoder.
`timescale 1ns / 1ps
`default_nettype none
package lcd_pkg;
    localparam int TABLE_ENTRIES = 512;
    localparam int BYTES_PER_RESULT = 8;
    localparam int LITERALS = 256;
    localparam int START_WIDTH = 9;
    localparam int STACK_DEPTH = TABLE_ENTRIES - 254;
    localparam int CODE_W = 10;
    localparam int TAB_AW = $clog2(TABLE_ENTRIES);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int LEN_W = 9;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 4;
    localparam int WID_W = 4;
    localparam int OUT_W = BYTES_PER_RESULT * BYTE_W;
    localparam int IDX_W = $clog2(BYTES_PER_RESULT);
    localparam int NF_W = CODE_W;

    typedef struct packed {
        logic [TAB_AW-1:0] prefix;
        logic [BYTE_W-1:0] tail;
        logic [BYTE_W-1:0] head;
        logic [LEN_W-1:0]  len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic accept;
        logic step;
        logic step_first;
        logic lit;
        logic upd;
        logic gather;
        logic flush;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic start_lit;
        logic prefix_lit;
        logic chunk_end;
        logic out_free;
        logic last_chunk;
    } t_status;
endpackage
`default_nettype wire

### sv/lcd_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/lcd_ctrl.sv
// Sequencer of the LZW code decoder: walk, table update, chunked output.
`timescale 1ns / 1ps
`default_nettype none
module lcd_ctrl
    import lcd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_FIRST, S_STEP, S_LIT, S_UPD, S_GATHER, S_FLUSH, S_PUSH
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.start_lit ? S_LIT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_FIRST;
            end
            S_FIRST: begin
                o_cmd.step = 1'b1;
                o_cmd.step_first = 1'b1;
                n_state = i_status.prefix_lit ? S_LIT : S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = i_status.prefix_lit ? S_LIT : S_STEP;
            end
            S_LIT: begin
                o_cmd.lit = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_GATHER;
            end
            S_GATHER: begin
                o_cmd.gather = 1'b1;
                if (i_status.chunk_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = i_status.last_chunk ? S_IDLE : S_GATHER;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule
`default_nettype wire

### sv/lcd_datapath.sv
// Datapath of the LZW code decoder: table, string stack, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_code_decoder_defines.svh"
module lcd_datapath
    import lcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic              i_first,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [OUT_W-1:0]       o_out_bytes,
    output logic [CNT_W-1:0]       o_byte_count,
    output logic                   o_last,
    output logic [WID_W-1:0]       o_next_width
);
    // persistent decoder state
    logic [NF_W-1:0]   r_nf;
    logic [WID_W-1:0]  r_cw;
    logic [TAB_AW-1:0] r_prev;
    logic [BYTE_W-1:0] r_prev_head;
    logic [LEN_W-1:0]  r_prev_len;
    // per-code working registers
    logic              r_first, r_unk;
    logic [TAB_AW-1:0] r_c, r_code;
    logic [STK_AW-1:0] r_pos, r_rd;
    logic [LEN_W-1:0]  r_n;
    logic [BYTE_W-1:0] r_ch;
    logic [IDX_W-1:0]  r_iss;
    logic [CNT_W-1:0]  r_got;
    logic [OUT_W-1:0]  r_word;
    logic              r_pend, r_ov;
    logic [OUT_W-1:0]  r_ob;
    logic [CNT_W-1:0]  r_bc;
    logic              r_last;
    logic [WID_W-1:0]  r_nw;

    logic [ENTRY_W-1:0] s_tab_rdata, s_tab_wdata;
    logic [TAB_AW-1:0]  s_tab_raddr;
    logic               s_tab_we;
    t_entry             s_ent, s_new;
    logic               s_stk_we;
    logic [STK_AW-1:0]  s_stk_waddr;
    logic [BYTE_W-1:0]  s_stk_wdata, s_stk_rdata;
    logic               s_unk, s_full, s_grow, s_cap;
    logic [TAB_AW-1:0]  s_start_c;
    logic [STK_AW-1:0]  s_pos;
    logic [NF_W-1:0]    s_nf_next;
    logic               s_wide, s_count_ok;

    assign s_ent     = t_entry'(s_tab_rdata);
    assign s_unk     = (i_code >= r_nf);
    assign s_start_c = s_unk ? r_prev : i_code[TAB_AW-1:0];
    assign s_full    = (r_nf == NF_W'(TABLE_ENTRIES));
    assign s_nf_next = s_full ? r_nf : r_nf + NF_W'(1);
    assign s_grow    = (16'(s_nf_next) == (16'd1 << r_cw));
    assign s_pos     = i_cmd.step_first ? STK_AW'(s_ent.len - LEN_W'(1)) : r_pos;
    assign s_cap     = (i_cmd.gather && r_pend) || i_cmd.flush;

    assign o_status.start_lit  = i_first || (s_start_c < TAB_AW'(LITERALS));
    assign o_status.prefix_lit = (s_ent.prefix < TAB_AW'(LITERALS));
    assign o_status.chunk_end  = (r_iss == IDX_W'(BYTES_PER_RESULT - 1)) ||
                                 (LEN_W'(r_rd) == r_n - LEN_W'(1));
    assign o_status.out_free   = !r_ov || !i_out_stall;
    assign o_status.last_chunk = (LEN_W'(r_rd) == r_n);

    // table: read the start code, then follow prefixes one per cycle
    assign s_tab_raddr  = i_cmd.step ? s_ent.prefix : r_c;
    assign s_tab_we     = i_cmd.upd && !r_first && !s_full;
    assign s_new.prefix = r_prev;
    assign s_new.tail   = r_ch;
    assign s_new.head   = r_prev_head;
    assign s_new.len    = r_prev_len + LEN_W'(1);
    assign s_tab_wdata  = s_new;

    lcd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (s_tab_we),
        .i_waddr (r_nf[TAB_AW-1:0]),
        .i_wdata (s_tab_wdata),
        .i_raddr (s_tab_raddr),
        .o_rdata (s_tab_rdata)
    );

    always_comb begin
        s_stk_we    = 1'b0;
        s_stk_waddr = r_pos;
        s_stk_wdata = r_c[BYTE_W-1:0];
        if (i_cmd.accept && !i_first && s_unk) begin
            // KwKwK: trailing byte is the previous head
            s_stk_we    = 1'b1;
            s_stk_waddr = STK_AW'(r_prev_len);
            s_stk_wdata = r_prev_head;
        end else if (i_cmd.step) begin
            s_stk_we    = 1'b1;
            s_stk_waddr = s_pos;
            s_stk_wdata = s_ent.tail;
        end else if (i_cmd.lit) begin
            s_stk_we    = 1'b1;
        end
    end

    lcd_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_stk_we),
        .i_waddr (s_stk_waddr),
        .i_wdata (s_stk_wdata),
        .i_raddr (r_rd),
        .o_rdata (s_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf        <= NF_W'(LITERALS);
            r_cw        <= WID_W'(START_WIDTH);
            r_prev      <= '0;
            r_prev_head <= '0;
            r_prev_len  <= LEN_W'(1);
            r_pend      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.accept && i_first) begin
                r_nf        <= NF_W'(LITERALS);
                r_cw        <= WID_W'(START_WIDTH);
                r_prev      <= TAB_AW'(i_code[BYTE_W-1:0]);
                r_prev_head <= i_code[BYTE_W-1:0];
                r_prev_len  <= LEN_W'(1);
            end
            if (i_cmd.upd && !r_first) begin
                r_nf <= s_nf_next;
                if (s_grow) begin
                    r_cw <= r_cw + WID_W'(1);
                end
                if (r_unk) begin
                    if (!s_full) begin
                        r_prev     <= r_nf[TAB_AW-1:0];
                        r_prev_len <= r_n;
                    end
                end else begin
                    r_prev      <= r_code;
                    r_prev_head <= r_ch;
                    r_prev_len  <= r_n;
                end
            end
            if (i_cmd.gather) begin
                r_pend <= 1'b1;
            end else if (i_cmd.flush || i_cmd.upd) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first <= i_first;
            r_unk   <= s_unk && !i_first;
            r_c     <= i_first ? TAB_AW'(i_code[BYTE_W-1:0]) : s_start_c;
            r_code  <= s_start_c;
            r_pos   <= '0;
            r_n     <= (!i_first && s_unk) ? r_prev_len + LEN_W'(1) : LEN_W'(1);
            r_ch    <= (!i_first && s_unk) ? r_prev_head : i_code[BYTE_W-1:0];
        end
        if (i_cmd.step) begin
            r_c   <= s_ent.prefix;
            r_pos <= s_pos - STK_AW'(1);
            if (i_cmd.step_first && !r_unk) begin
                r_n  <= s_ent.len;
                r_ch <= s_ent.head;
            end
        end
        if (i_cmd.upd) begin
            r_rd   <= '0;
            r_iss  <= '0;
            r_got  <= '0;
            r_word <= '0;
        end
        if (i_cmd.gather) begin
            r_rd  <= r_rd + STK_AW'(1);
            r_iss <= r_iss + IDX_W'(1);
        end
        if (s_cap) begin
            r_word[BYTE_W*r_got[IDX_W-1:0] +: BYTE_W] <= s_stk_rdata;
            r_got <= r_got + CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_ob   <= r_word;
            r_bc   <= r_got;
            r_last <= (LEN_W'(r_rd) == r_n);
            r_nw   <= r_cw;
            r_word <= '0;
            r_iss  <= '0;
            r_got  <= '0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_bytes  = r_ob;
    assign o_byte_count = r_bc;
    assign o_last       = r_last;
    assign o_next_width = r_nw;

    assign s_wide     = (r_cw == WID_W'(START_WIDTH + 1));
    assign s_count_ok = (r_bc != '0) && (r_bc <= CNT_W'(BYTES_PER_RESULT));

    `LCD_ASSERT_ALWAYS(a_width_tracks_fill, s_wide == s_full, "width out of step with fill")
    `LCD_ASSERT_IMPLY(a_count_range, o_out_valid, s_count_ok, "byte count out of range")
    `LCD_ASSERT_IMPLY(a_push_has_room, i_cmd.push, !r_ov || !i_out_stall, "push over held result")
endmodule
`default_nettype wire

### sv/lzw_code_decoder.sv
// Top level of the LZW code decoder: unpacked codes in, decoded byte chunks out.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_code, i_first
//  out     | output    | o_out_valid / i_out_stall  | o_out_bytes, o_byte_count, o_last,
//          |           |                            | o_next_width
//
// From the input transfer to the table update a table code walks its prefixes with one
// table read per prefix step (the table RAM port sets the pace); a literal skips the walk.
// Each output chunk of k bytes then takes k stack reads, a flush and a push; the longest
// string (258 bytes) is sent as 33 chunks.
// Reset (i_rst_n low, synchronous) empties the output register and restores the width
// to 9, next free code to 256 and the previous code to a single zero byte.
// An output stall holds the sequencer in its push step; input is taken only when idle,
// and a finished result may still wait in the output register at that point.
`timescale 1ns / 1ps
`default_nettype none
module lzw_code_decoder
    import lcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic              i_first,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [OUT_W-1:0]       o_out_bytes,
    output logic [CNT_W-1:0]       o_byte_count,
    output logic                   o_last,
    output logic [WID_W-1:0]       o_next_width
);
    t_cmd    s_cmd;
    t_status s_status;

    // sequencer: one transfer in, then walk, update, and chunked transfers out
    lcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    // table, string stack and output register
    lcd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_status     (s_status),
        .i_code       (i_code),
        .i_first      (i_first),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_bytes  (o_out_bytes),
        .o_byte_count (o_byte_count),
        .o_last       (o_last),
        .o_next_width (o_next_width)
    );
endmodule
`default_nettype wire
